>>> rtl/core/indexed_doubly_linked_list_unit_macros.svh
// Assertion macros for the indexed doubly linked list unit.
// Used by idll_checker; no other dependencies.
`ifndef INDEXED_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH

// Assert a property on the rising edge, disabled while reset is low.
`define IDLL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assert a property on the rising edge, checked through reset too.
`define IDLL_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/idll_pkg.sv
// Package for the indexed doubly linked list unit: beat types, request and
// status codes, controller command and status structs. No dependencies.
`timescale 1ns / 1ps

package idll_pkg;

  localparam int SLOTS_DEF      = 256;
  localparam int VALUE_BITS_DEF = 16;
  localparam int ANCHOR_W       = 8;
  localparam int VAL_W          = 16;
  localparam int SLOT_W         = 8;

  typedef enum logic [1:0] {
    REQ_INS_AFTER  = 2'd0,
    REQ_INS_BEFORE = 2'd1,
    REQ_ERASE      = 2'd2,
    REQ_READ       = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_GONE = 2'd3
  } status_t;

  typedef struct packed {
    req_kind_t             req_type;
    logic [ANCHOR_W-1:0]   anchor_slot;
    logic [VAL_W-1:0]      item_value;
  } in_beat_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     new_slot;
    logic [VAL_W-1:0]      read_value;
    logic [SLOT_W-1:0]     read_prev;
    logic [SLOT_W-1:0]     read_next;
  } out_beat_t;

  typedef struct packed {
    logic latch_req;
    logic look;
    logic eval;
    logic link2;
    logic load_out;
  } idll_cmd_t;

  typedef struct packed {
    logic ins_go;
  } idll_sts_t;

endpackage

>>> rtl/core/idll_ctrl.sv
// Controller state machine of the linked list unit: sequences lookup,
// evaluate, link and result load. Depends on idll_pkg.
`timescale 1ns / 1ps

module idll_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output idll_pkg::idll_cmd_t   cmd,
  input  idll_pkg::idll_sts_t   sts
);
  import idll_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_EVAL = 5'b00100,
    S_LINK = 5'b01000,
    S_DONE = 5'b10000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.ins_go ? S_LINK : S_DONE;
      end
      S_LINK: begin
        cmd.link2 = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/idll_dp.sv
// Datapath of the linked list unit: slot value, link and removed-flag
// memories, sentinel link registers, fill count and result registers. Uses idll_pkg.
`timescale 1ns / 1ps

module idll_dp #(
  parameter int SLOTS      = idll_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = idll_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  idll_pkg::idll_cmd_t   cmd,
  output idll_pkg::idll_sts_t   sts,
  input  idll_pkg::in_beat_t    in_data,
  output idll_pkg::out_beat_t   out_data
);
  import idll_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int EW = (SW > ANCHOR_W) ? SW : ANCHOR_W;
  localparam int VW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  logic [SW-1:0] prev_mem [SLOTS];
  logic [SW-1:0] next_mem [SLOTS];
  logic [VW-1:0] val_mem  [SLOTS];
  logic          rm_mem   [SLOTS];

  req_kind_t           kind_r;
  logic [ANCHOR_W-1:0] anch_r;
  logic [VW-1:0]       item_r;
  logic [SW-1:0]       used_r;
  logic [SW-1:0]       prev0_r, next0_r;
  logic [SW-1:0]       pl_rd_r, nl_rd_r;
  logic [VW-1:0]       val_rd_r;
  logic                rm_rd_r;
  out_beat_t           res_r, res_nxt;
  out_beat_t           out_r;

  logic [EW-1:0] anch_x, n_x, pl_x, nl_x;
  logic [SW-1:0] s_addr, n_slot, pl, nl;
  logic          s_zero, in_range, rem, is_ins, op_ok, p1, p2;
  status_t       st;
  logic          prev_we, next_we;
  logic [SW-1:0] prev_wa, prev_wd, next_wa, next_wd, rm_wa;

  assign anch_x   = EW'(anch_r);
  assign s_addr   = anch_x[SW-1:0];
  assign s_zero   = (anch_r == '0);
  assign in_range = (anch_x <= EW'(used_r));
  assign n_slot   = used_r + SW'(1);
  assign n_x      = EW'(n_slot);
  assign pl       = s_zero ? prev0_r : pl_rd_r;
  assign nl       = s_zero ? next0_r : nl_rd_r;
  assign pl_x     = EW'(pl);
  assign nl_x     = EW'(nl);
  assign rem      = !s_zero && rm_rd_r;
  assign is_ins   = (kind_r == REQ_INS_AFTER) || (kind_r == REQ_INS_BEFORE);

  always_comb begin
    case (kind_r)
      REQ_INS_AFTER, REQ_INS_BEFORE: begin
        if (!in_range || rem) begin
          st = ST_BAD;
        end else if (used_r == LAST) begin
          st = ST_FULL;
        end else begin
          st = ST_OK;
        end
      end
      REQ_ERASE: begin
        if (s_zero || !in_range) begin
          st = ST_BAD;
        end else if (rem) begin
          st = ST_GONE;
        end else begin
          st = ST_OK;
        end
      end
      REQ_READ: begin
        st = in_range ? ST_OK : ST_BAD;
      end
      default: begin
        st = ST_BAD;
      end
    endcase
  end

  assign op_ok      = (st == ST_OK);
  assign sts.ins_go = is_ins && op_ok;
  assign p1         = cmd.eval && op_ok && (kind_r != REQ_READ);
  assign p2         = cmd.link2;
  assign rm_wa      = is_ins ? n_slot : s_addr;

  always_comb begin
    res_nxt            = '0;
    res_nxt.status     = st;
    if (is_ins && op_ok) begin
      res_nxt.new_slot = n_x[SLOT_W-1:0];
    end
    if ((kind_r == REQ_READ) && op_ok) begin
      res_nxt.read_value = s_zero ? '0 : VAL_W'(val_rd_r);
      res_nxt.read_prev  = pl_x[SLOT_W-1:0];
      res_nxt.read_next  = nl_x[SLOT_W-1:0];
    end
  end

  always_comb begin
    prev_we = 1'b0;
    prev_wa = n_slot;
    prev_wd = s_addr;
    next_we = 1'b0;
    next_wa = n_slot;
    next_wd = nl;
    if (p1) begin
      case (kind_r)
        REQ_INS_AFTER: begin
          prev_we = 1'b1;
          prev_wa = n_slot;
          prev_wd = s_addr;
          next_we = 1'b1;
          next_wa = n_slot;
          next_wd = nl;
        end
        REQ_INS_BEFORE: begin
          prev_we = 1'b1;
          prev_wa = n_slot;
          prev_wd = pl;
          next_we = 1'b1;
          next_wa = n_slot;
          next_wd = s_addr;
        end
        REQ_ERASE: begin
          prev_we = 1'b1;
          prev_wa = nl;
          prev_wd = pl;
          next_we = 1'b1;
          next_wa = pl;
          next_wd = nl;
        end
        default: begin
        end
      endcase
    end else if (p2) begin
      case (kind_r)
        REQ_INS_AFTER: begin
          prev_we = 1'b1;
          prev_wa = nl;
          prev_wd = used_r;
          next_we = 1'b1;
          next_wa = s_addr;
          next_wd = used_r;
        end
        REQ_INS_BEFORE: begin
          prev_we = 1'b1;
          prev_wa = s_addr;
          prev_wd = used_r;
          next_we = 1'b1;
          next_wa = pl;
          next_wd = used_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev0_r <= '0;
      next0_r <= '0;
      used_r  <= '0;
    end else begin
      if (prev_we && (prev_wa == '0)) begin
        prev0_r <= prev_wd;
      end
      if (next_we && (next_wa == '0)) begin
        next0_r <= next_wd;
      end
      if (p1 && is_ins) begin
        used_r <= n_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (cmd.look) begin
      pl_rd_r <= prev_mem[s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (cmd.look) begin
      nl_rd_r <= next_mem[s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (p1 && is_ins) begin
      val_mem[n_slot] <= item_r;
    end
    if (cmd.look) begin
      val_rd_r <= val_mem[s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (p1) begin
      rm_mem[rm_wa] <= !is_ins;
    end
    if (cmd.look) begin
      rm_rd_r <= rm_mem[s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      kind_r <= in_data.req_type;
      anch_r <= in_data.anchor_slot;
      item_r <= in_data.item_value[VW-1:0];
    end
    if (cmd.eval) begin
      res_r <= res_nxt;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/core/indexed_doubly_linked_list_unit.sv
// Indexed doubly linked list unit: top level joining idll_ctrl and idll_dp; uses idll_pkg.
// A request passes lookup, evaluate, a second link write (inserts only) and result load;
// the result load waits while the output is stalled. No new request is taken until the
// controller is back in idle, as this sequence runs on the link memories one at a time.
// Reset (synchronous, active low) clears controller, fill count and sentinel links;
// no clearing pass, so the unit takes requests in the first cycle after reset.
`timescale 1ns / 1ps

module indexed_doubly_linked_list_unit #(
  parameter int SLOTS      = idll_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = idll_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  idll_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output idll_pkg::out_beat_t  out_data
);
  import idll_pkg::*;

  idll_cmd_t cmd;
  idll_sts_t sts;

  idll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  idll_dp #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/idll_checker.sv
// Port checker for the indexed doubly linked list unit, bound to the top level.
// Depends on idll_pkg and indexed_doubly_linked_list_unit_macros.svh.
`timescale 1ns / 1ps
`include "indexed_doubly_linked_list_unit_macros.svh"

module idll_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input idll_pkg::in_beat_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input idll_pkg::out_beat_t  out_data
);
  import idll_pkg::*;

  logic in_take, in_wait, out_wait, fail_beat, data_clear;

  assign in_take    = in_valid && !in_stall;
  assign in_wait    = in_valid && in_stall;
  assign out_wait   = out_valid && out_stall;
  assign fail_beat  = out_valid && (out_data.status != ST_OK);
  assign data_clear = (out_data.new_slot == '0) && (out_data.read_value == '0) &&
                      (out_data.read_prev == '0) && (out_data.read_next == '0);

  `IDLL_ASSERT(a_one_at_a_time, clk, rst_n, in_take |=> in_stall, "accepted while busy")

  `IDLL_ASSERT(a_in_hold, clk, rst_n, in_wait |=> in_valid && $stable(in_data), "input moved")

  `IDLL_ASSERT(a_out_hold, clk, rst_n, out_wait |=> out_valid && $stable(out_data), "beat moved")

  `IDLL_ASSERT(a_fail_zero, clk, rst_n, fail_beat |-> data_clear, "rejected beat carries data")

  `IDLL_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !out_valid && !in_stall, "busy after reset")

endmodule

bind indexed_doubly_linked_list_unit idll_checker u_idll_checker (.*);
